[hdl/mset_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mset_pkg: shared types and constants of the multi-slot expiry timer
// request codes, transaction structs and size limits
// ----------------------------------------------------------------------------
package mset_pkg;

  localparam int DefNumSlots = 8;
  localparam int MaxResults  = 8;
  localparam int MillisDiv   = 1000;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_CREATE = 3'd1,
    REQ_START  = 3'd2,
    REQ_STOP   = 3'd3,
    REQ_DELETE = 3'd4,
    REQ_POLL   = 3'd5,
    REQ_READ   = 3'd6,
    REQ_NONE   = 3'd7
  } req_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  slot_number;
    logic [31:0] timeout_period;
    logic        repeat_mode;
    logic        handler_present;
  } req_item_t;

  typedef struct packed {
    logic        success;
    logic [2:0]  result_slot;
    logic        expired;
    logic [31:0] micros_now;
    logic [31:0] millis_now;
    logic        last_of_run;
  } rsp_item_t;

endpackage

[hdl/mset_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mset_fifo: small request queue
// decouples the front end from the slot engine
// ----------------------------------------------------------------------------
module mset_fifo #(
  parameter int Depth = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  mset_pkg::req_item_t wdata,
  output logic                full,
  input  logic                rd,
  output mset_pkg::req_item_t rdata,
  output logic                empty
);
  import mset_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  req_item_t         mem [Depth];
  logic [AW-1:0]     wp;
  logic [AW-1:0]     rp;
  logic [AW:0]       cnt;

  assign full  = (cnt == (AW+1)'(Depth));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wp] <= wdata;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr && !full) begin
        wp <= (wp == AW'(Depth - 1)) ? '0 : wp + 1'b1;
      end
      if (rd && !empty) begin
        rp <= (rp == AW'(Depth - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end

endmodule

[hdl/mset_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mset_divider: radix-2 restoring divider
// 64 by 32 bit unsigned remainder, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mset_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);
  import mset_pkg::*;

  logic [63:0] quo;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [6:0]  cnt;
  logic        busy;
  logic [33:0] trial;

  // partial remainder stays below the divisor, so the shifted value needs 33 bits
  assign trial     = {1'b0, rem, quo[63]} - {2'b0, dsr};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
        cnt  <= 7'd64;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial[31:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/mset_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mset_engine: slot table and request sequencer
// carries out one queued request at a time, writes results to an output queue
// ----------------------------------------------------------------------------
module mset_engine #(
  parameter int NumSlots = mset_pkg::DefNumSlots
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  mset_pkg::req_item_t req,
  output logic                req_take,
  output logic                rsp_empty,
  input  logic                rsp_pop,
  output mset_pkg::rsp_item_t rsp
);
  import mset_pkg::*;

  localparam int SW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int QW = $clog2(MaxResults);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_DIV, S_NEAR, S_EMPTY
  } state_t;

  state_t         state;
  req_item_t      cur;
  logic [63:0]    up_us;
  logic [31:0]    up_ms;
  logic [9:0]     ms_rem;
  logic [NumSlots-1:0] alloc;
  logic [NumSlots-1:0] armed;
  logic [NumSlots-1:0] rpt;
  logic [NumSlots-1:0] hnd;
  logic [31:0]    period [NumSlots];
  logic [63:0]    deadline [NumSlots];
  logic [63:0]    near_dl;
  logic           near_vld;
  logic [SW:0]    idx;
  logic [SW-1:0]  sidx;
  logic [63:0]    best;
  logic           found;
  logic [3:0]     nres;
  logic           handled;

  // output queue
  rsp_item_t      oq [MaxResults];
  logic [QW-1:0]  owp;
  logic [QW-1:0]  orp;
  logic [QW:0]    ocnt;
  logic           opush;
  rsp_item_t      oitem;
  logic           held;
  rsp_item_t      hitem;

  // catch-up divider: new deadline is now - (now - deadline) mod period + period
  logic           div_start;
  logic           div_done;
  logic [31:0]    div_r;

  mset_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(up_us - deadline[sidx]), .divisor(period[sidx]),
    .done(div_done), .remainder(div_r)
  );

  logic [SW-1:0] free_idx;
  logic          free_ok;
  logic          addr_ok;
  logic [SW-1:0] aslot;

  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (!alloc[i]) begin
        free_ok  = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign addr_ok  = ({4'b0, cur.slot_number} < 7'(NumSlots));
  assign aslot    = SW'(cur.slot_number);
  assign sidx     = idx[SW-1:0];
  assign rsp_empty = (ocnt == '0);
  assign rsp       = oq[orp];
  // space for a full poll burst before a new request starts
  assign req_take  = (state == S_IDLE) && req_valid && (ocnt == '0) && !opush && !held;

  always_ff @(posedge clk) begin
    if (opush) begin
      oq[owp] <= oitem;
    end
    if (rst) begin
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      if (opush) owp <= owp + 1'b1;
      if (rsp_pop && !rsp_empty) orp <= orp + 1'b1;
      ocnt <= ocnt + (QW+1)'(opush) - (QW+1)'(rsp_pop && !rsp_empty);
    end
  end

  function automatic rsp_item_t mk(logic s, logic [2:0] sl, logic e,
                                   logic [31:0] us, logic [31:0] ms, logic l);
    rsp_item_t r;
    r.success = s; r.result_slot = sl; r.expired = e;
    r.micros_now = us; r.millis_now = ms; r.last_of_run = l;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      up_us    <= '0;
      up_ms    <= '0;
      ms_rem   <= '0;
      alloc    <= '0;
      armed    <= '0;
      near_dl  <= '0;
      near_vld <= 1'b0;
      opush    <= 1'b0;
      held     <= 1'b0;
      div_start <= 1'b0;
      idx      <= '0;
      nres     <= '0;
      handled  <= 1'b0;
    end else begin
      opush     <= 1'b0;
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          // a held poll result is flushed as last once the scan ends
          if (req_take) begin
            cur   <= req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          unique case (req_t'(cur.req_type))
            REQ_TICK: begin
              up_us <= up_us + 64'd1;
              if (ms_rem == 10'(MillisDiv - 1)) begin
                ms_rem <= '0;
                up_ms  <= up_ms + 32'd1;
              end else begin
                ms_rem <= ms_rem + 10'd1;
              end
            end
            REQ_CREATE: begin
              opush <= 1'b1;
              oitem <= free_ok ? mk(1'b1, 3'(free_idx), 1'b0, '0, '0, 1'b1)
                               : mk(1'b0, 3'd0, 1'b0, '0, '0, 1'b1);
              if (free_ok) begin
                alloc[free_idx]  <= 1'b1;
                armed[free_idx]  <= 1'b0;
                rpt[free_idx]    <= cur.repeat_mode;
                hnd[free_idx]    <= cur.handler_present;
                period[free_idx] <= cur.timeout_period;
              end
            end
            REQ_START: begin
              opush <= 1'b1;
              oitem <= mk(addr_ok && alloc[aslot] && hnd[aslot], 3'd0, 1'b0, '0, '0, 1'b1);
              if (addr_ok && alloc[aslot] && hnd[aslot]) begin
                deadline[aslot] <= up_us + {32'b0, period[aslot]};
                armed[aslot]    <= 1'b1;
                state <= S_NEAR;
                idx   <= '0;
                found <= 1'b0;
              end
            end
            REQ_STOP, REQ_DELETE: begin
              if (addr_ok && alloc[aslot]) begin
                armed[aslot] <= 1'b0;
                if (req_t'(cur.req_type) == REQ_DELETE) alloc[aslot] <= 1'b0;
                state <= S_NEAR;
                idx   <= '0;
                found <= 1'b0;
              end
            end
            REQ_POLL: begin
              nres    <= '0;
              handled <= 1'b0;
              idx     <= '0;
              if (near_vld && up_us >= near_dl) state <= S_SCAN;
              else state <= S_EMPTY;
            end
            REQ_READ: begin
              opush <= 1'b1;
              oitem <= mk(1'b1, 3'd0, 1'b0, up_us[31:0], up_ms, 1'b1);
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (idx == (SW+1)'(NumSlots)) begin
            if (held) begin
              opush <= 1'b1;
              oitem <= mk(1'b1, hitem.result_slot, 1'b1, '0, '0, 1'b1);
              held  <= 1'b0;
            end
            if (handled) begin
              state <= S_NEAR;
              idx   <= '0;
              found <= 1'b0;
            end else begin
              state <= S_EMPTY;
            end
          end else if (alloc[sidx] && armed[sidx] && up_us >= deadline[sidx]) begin
            handled <= 1'b1;
            if (nres < 4'(MaxResults)) begin
              if (held) begin
                opush <= 1'b1;
                oitem <= hitem;
              end
              held  <= 1'b1;
              hitem <= mk(1'b1, 3'(sidx), 1'b1, '0, '0, 1'b0);
              nres  <= nres + 4'd1;
            end
            if (rpt[sidx] && period[sidx] != '0) begin
              div_start <= 1'b1;
              state     <= S_DIV;
            end else begin
              armed[sidx] <= 1'b0;
              idx <= idx + 1'b1;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DIV: begin
          // first deadline past now: drop the partial period, add one full period
          if (div_done) begin
            deadline[sidx] <= up_us - {32'b0, div_r} + {32'b0, period[sidx]};
            idx   <= idx + 1'b1;
            state <= S_SCAN;
          end
        end
        S_NEAR: begin
          if (idx == (SW+1)'(NumSlots)) begin
            near_vld <= found;
            near_dl  <= found ? best : 64'd0;
            state    <= S_IDLE;
          end else begin
            if (alloc[sidx] && armed[sidx] && (!found || deadline[sidx] < best)) begin
              best  <= deadline[sidx];
              found <= 1'b1;
            end
            idx <= idx + 1'b1;
          end
        end
        S_EMPTY: begin
          state <= S_IDLE;
          if (nres == '0) begin
            opush <= 1'b1;
            oitem <= mk(1'b1, 3'd0, 1'b0, '0, '0, 1'b1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/multi_slot_expiry_timer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_expiry_timer: microsecond uptime with a table of expiry slots
// front request queue feeding a sequential slot engine with a result queue
// ----------------------------------------------------------------------------
// requests: the exec state carries out each taken request; start, stop and
// delete that take effect then hold the engine for the nearest-deadline scan
// poll: one scan over all slots, a 64-step divider run per periodic catch-up,
// plus the nearest-deadline scan when a slot fired
// throughput: one request at a time in the engine; a new one starts only once
// all results of the previous request are popped
// reset: synchronous rst clears uptime, slot allocation, arming and queues
module multi_slot_expiry_timer #(
  parameter int NumSlots = mset_pkg::DefNumSlots
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mset_pkg::req_item_t req,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output mset_pkg::rsp_item_t rsp
);
  import mset_pkg::*;

  req_item_t q_data;
  logic      q_empty;
  logic      q_take;

  // request transaction queue
  mset_fifo #(.Depth(4)) u_fifo (
    .clk(clk), .rst(rst), .wr(push), .wdata(req), .full(full),
    .rd(q_take), .rdata(q_data), .empty(q_empty)
  );

  // slot engine with its own result queue
  mset_engine #(.NumSlots(NumSlots)) u_engine (
    .clk(clk), .rst(rst), .req_valid(!q_empty), .req(q_data), .req_take(q_take),
    .rsp_empty(empty), .rsp_pop(pop), .rsp(rsp)
  );

endmodule

[hdl/mset_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mset_checker: port-level checks of the expiry timer
// bound to the top level
// ----------------------------------------------------------------------------
module mset_checker (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input mset_pkg::rsp_item_t rsp
);
  import mset_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(rsp)) else $error("result changed");
  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> empty && !full) else $error("queues not clear after reset");
  a_nofire_last: assert property (@(posedge clk) disable iff (rst)
    !empty && !rsp.expired && !rsp.success |-> rsp.last_of_run)
    else $error("failed result not last");
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && rsp.expired |-> rsp.micros_now == '0 && rsp.success)
    else $error("poll result fields");

endmodule

bind multi_slot_expiry_timer mset_checker u_chk (
  .clk(clk), .rst(rst), .full(full),
  .empty(empty), .pop(pop), .rsp(rsp)
);
